FILE: src/mcpd_pkg.sv
package mcpd_pkg;

   localparam int CHANNELS = 8;
   localparam int CH_W     = 3;
   localparam int KIND_W   = 3;
   localparam int DATA_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W    = $clog2(DIV_STEPS);

   localparam logic [DATA_W-1:0] BRIGHT_RST = 8'd100;
   localparam logic [DATA_W-1:0] DELAY_RST  = 8'd100;

   localparam logic [KIND_W-1:0] KIND_ZERO = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TICK = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ON   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OFF  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_GET  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BRIGHTNESS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BRIGHTNESS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DELAY      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELAY      = 3'd4;

   typedef struct packed {
      logic load;
      logic clamp;
      logic mul_go;
      logic div_start;
      logic apply;
   } mcpd_cmd_type;

   typedef struct packed {
      logic is_set;
      logic range_ok;
      logic div_busy;
   } mcpd_status_type;

endpackage

FILE: src/mcpd_div.sv
module mcpd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mcpd_pkg::PROD_W-1:0]   dividend,
   input  logic [mcpd_pkg::DATA_W-1:0]   divisor,
   output logic                          busy,
   output logic [mcpd_pkg::PROD_W-1:0]   quotient
);
   import mcpd_pkg::*;

   logic              busy_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;
   logic              ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[PROD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_in  = {quo_ff[PROD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/mcpd_dp.sv
module mcpd_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  mcpd_pkg::mcpd_cmd_type           cmd,
   output mcpd_pkg::mcpd_status_type        st,
   input  logic [mcpd_pkg::KIND_W-1:0]      req_kind,
   input  logic [mcpd_pkg::CH_W-1:0]        req_channel,
   input  logic [mcpd_pkg::DATA_W-1:0]      req_value,
   input  logic                             csr_we,
   input  logic [mcpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mcpd_pkg::DATA_W-1:0]      csr_data,
   output logic [mcpd_pkg::CHANNELS-1:0]    rsp_gate_outputs,
   output logic [mcpd_pkg::DATA_W-1:0]      rsp_brightness_reported
);
   import mcpd_pkg::*;

   logic [KIND_W-1:0] kind_ff;
   logic [CH_W-1:0]   chan_ff;
   logic [DATA_W-1:0] value_ff;

   logic [CHANNELS-1:0] enable_ff;
   logic [DATA_W-1:0]   minb_ff, maxb_ff, mind_ff, maxd_ff;

   logic [DATA_W-1:0] bnow_ff [CHANNELS];
   logic [DATA_W-1:0] bsav_ff [CHANNELS];
   logic [DATA_W-1:0] dnow_ff [CHANNELS];
   logic [DATA_W-1:0] dsav_ff [CHANNELS];
   logic [DATA_W-1:0] tick_ff [CHANNELS];
   logic [CHANNELS-1:0] armed_ff;
   logic [CHANNELS-1:0] gate_ff;

   logic [DATA_W-1:0] bnow_in [CHANNELS];
   logic [DATA_W-1:0] bsav_in [CHANNELS];
   logic [DATA_W-1:0] dnow_in [CHANNELS];
   logic [DATA_W-1:0] dsav_in [CHANNELS];
   logic [DATA_W-1:0] tick_in [CHANNELS];
   logic [CHANNELS-1:0] armed_in;
   logic [CHANNELS-1:0] gate_in;

   logic [DATA_W-1:0] v_ff, v_in, lo_clamp;
   logic              neg_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] diff_b, dmag, range_b, q8, set_delay, report;
   logic [PROD_W-1:0] quotient;
   logic              div_busy, range_ok;

   logic [CHANNELS-1:0] gates_ff;
   logic [DATA_W-1:0]   report_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         minb_ff   <= '0;
         maxb_ff   <= BRIGHT_RST;
         mind_ff   <= '0;
         maxd_ff   <= DELAY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_ENABLE: enable_ff <= csr_data;
            CSR_MIN_BRIGHTNESS: minb_ff   <= csr_data;
            CSR_MAX_BRIGHTNESS: maxb_ff   <= csr_data;
            CSR_MIN_DELAY:      mind_ff   <= csr_data;
            CSR_MAX_DELAY:      maxd_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         chan_ff  <= req_channel;
         value_ff <= req_value;
      end
      if (cmd.clamp) begin
         v_ff <= v_in;
      end
      if (cmd.mul_go) begin
         prod_ff <= prod_in;
         neg_ff  <= maxd_ff < mind_ff;
      end
   end

   // brightness map: saturate, multiply, divide, offset from min delay
   always_comb begin
      lo_clamp  = (value_ff < minb_ff) ? minb_ff : value_ff;
      v_in      = (lo_clamp > maxb_ff) ? maxb_ff : lo_clamp;
      diff_b    = v_ff - minb_ff;
      dmag      = (maxd_ff < mind_ff) ? (mind_ff - maxd_ff) : (maxd_ff - mind_ff);
      prod_in   = PROD_W'(diff_b) * PROD_W'(dmag);
      range_b   = maxb_ff - minb_ff;
      range_ok  = maxb_ff > minb_ff;
      q8        = quotient[DATA_W-1:0];
      set_delay = !range_ok ? mind_ff : (neg_ff ? (mind_ff - q8) : (mind_ff + q8));
   end

   mcpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (range_b),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         bnow_in[i] = bnow_ff[i];
         bsav_in[i] = bsav_ff[i];
         dnow_in[i] = dnow_ff[i];
         dsav_in[i] = dsav_ff[i];
         tick_in[i] = tick_ff[i];
      end
      armed_in = armed_ff;
      gate_in  = gate_ff;
      report   = '0;
      unique case (kind_ff)
         KIND_ZERO: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (enable_ff[i]) begin
                  armed_in[i] = 1'b1;
                  tick_in[i]  = '0;
                  gate_in[i]  = 1'b0;
               end
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (enable_ff[i] && armed_ff[i] && dnow_ff[i] != mind_ff) begin
                  if (tick_ff[i] >= dnow_ff[i]) begin
                     gate_in[i]  = 1'b1;
                     tick_in[i]  = '0;
                     armed_in[i] = 1'b0;
                  end else if (tick_ff[i] != '1) begin
                     tick_in[i] = tick_ff[i] + 1'b1;
                  end
               end
            end
         end
         KIND_SET: begin
            bsav_in[chan_ff] = bnow_ff[chan_ff];
            bnow_in[chan_ff] = v_ff;
            dnow_in[chan_ff] = set_delay;
         end
         KIND_ON: begin
            bnow_in[chan_ff] = bsav_ff[chan_ff];
            dnow_in[chan_ff] = dsav_ff[chan_ff];
         end
         KIND_OFF: begin
            bsav_in[chan_ff] = bnow_ff[chan_ff];
            dsav_in[chan_ff] = dnow_ff[chan_ff];
            bnow_in[chan_ff] = minb_ff;
            dnow_in[chan_ff] = mind_ff;
         end
         KIND_GET: begin
            report = (bnow_ff[chan_ff] == minb_ff) ? bsav_ff[chan_ff] : bnow_ff[chan_ff];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            bnow_ff[i] <= BRIGHT_RST;
            bsav_ff[i] <= BRIGHT_RST;
            dnow_ff[i] <= DELAY_RST;
            dsav_ff[i] <= DELAY_RST;
            tick_ff[i] <= '0;
         end
         armed_ff <= '0;
         gate_ff  <= '0;
      end else if (cmd.apply) begin
         for (int i = 0; i < CHANNELS; i++) begin
            bnow_ff[i] <= bnow_in[i];
            bsav_ff[i] <= bsav_in[i];
            dnow_ff[i] <= dnow_in[i];
            dsav_ff[i] <= dsav_in[i];
            tick_ff[i] <= tick_in[i];
         end
         armed_ff <= armed_in;
         gate_ff  <= gate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         gates_ff  <= gate_in;
         report_ff <= report;
      end
   end

   assign rsp_gate_outputs        = gates_ff;
   assign rsp_brightness_reported = report_ff;

   assign st.is_set   = kind_ff == KIND_SET;
   assign st.range_ok = range_ok;
   assign st.div_busy = div_busy;

endmodule

FILE: src/mcpd_ctrl.sv
module mcpd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  mcpd_pkg::mcpd_status_type  st,
   output mcpd_pkg::mcpd_cmd_type     cmd
);
   import mcpd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DSTART = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_APPLY  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.clamp = 1'b1;
            state_in  = (st.is_set && st.range_ok) ? S_MUL : S_APPLY;
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!st.div_busy) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.apply || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EXEC))
      else $error("accepted item did not start execution");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_APPLY))
      else $error("result appeared without an apply");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && rsp_valid_ff && rsp_stall) |=> (state_ff == S_APPLY))
      else $error("state updated while result register was occupied");
`endif

endmodule

FILE: src/multi_channel_phase_dimmer_unit.sv
// Eight-channel phase-angle dimmer.
// Request channel (req_valid/req_stall) carries one item: kind, channel, value.
// Kinds: zero cross, tick, set brightness, turn on, turn off, get brightness.
// Every item returns exactly one result on rsp_valid/rsp_stall: the gate levels
// after the item and, for a get, the reported brightness (zero otherwise).
// Configuration writes arrive on csr_valid/csr_ready (always ready), indexed
// 0 enable, 1 min brightness, 2 max brightness, 3 min delay, 4 max delay;
// write them only while no item is in flight.
// Every item is saturated and then applied; a set brightness with a
// non-empty brightness range instead goes saturate, multiply, divider start,
// 16 steps of a restoring divider (one quotient bit each), a wait state that
// sees it finish, then apply. One item is processed at a time: no new item is
// taken until the last one has been applied. The next item is
// taken the cycle after the result is loaded, even if it still waits downstream.
// While the receiver stalls, the result holds and a finished item waits
// without touching channel state until the result register frees up.
// Reset (synchronous, active high) restores defaults: brightness and delay
// 100 on every channel, all gates low, nothing armed.
module multi_channel_phase_dimmer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mcpd_pkg::KIND_W-1:0]     req_kind,
   input  logic [mcpd_pkg::CH_W-1:0]       req_channel,
   input  logic [mcpd_pkg::DATA_W-1:0]     req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mcpd_pkg::CHANNELS-1:0]   rsp_gate_outputs,
   output logic [mcpd_pkg::DATA_W-1:0]     rsp_brightness_reported,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mcpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcpd_pkg::DATA_W-1:0]     csr_data
);
   import mcpd_pkg::*;

   mcpd_cmd_type    cmd;
   mcpd_status_type st;

   assign csr_ready = 1'b1;

   mcpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   mcpd_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .st                      (st),
      .req_kind                (req_kind),
      .req_channel             (req_channel),
      .req_value               (req_value),
      .csr_we                  (csr_valid && csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .rsp_gate_outputs        (rsp_gate_outputs),
      .rsp_brightness_reported (rsp_brightness_reported)
   );

endmodule

FILE: tb/multi_channel_phase_dimmer_unit_test.sv
module multi_channel_phase_dimmer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mcpd_pkg::*;

   localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd7;
   localparam int IDLE_PCT     = 35;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 900;
   localparam int PHASE_ITEMS  = 150;

   typedef struct packed {
      logic [CHANNELS-1:0] gates;
      logic [DATA_W-1:0]   bright;
   } dimmer_rsp_type;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type         row;
      logic [KIND_W-1:0]    kind;
      logic [CH_W-1:0]      ch;
      logic [DATA_W-1:0]    value;
      logic [CSR_IDX_W-1:0] idx;
      dimmer_rsp_type       rsp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [KIND_W-1:0]      req_kind = '0;
   logic [CH_W-1:0]        req_channel = '0;
   logic [DATA_W-1:0]      req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHANNELS-1:0]    rsp_gate_outputs;
   logic [DATA_W-1:0]      rsp_brightness_reported;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [DATA_W-1:0]      csr_data = '0;

   logic [DATA_W-1:0] cfg_enable, cfg_min_b, cfg_max_b, cfg_min_d, cfg_max_d;
   logic [DATA_W-1:0] bright_now [CHANNELS];
   logic [DATA_W-1:0] bright_saved [CHANNELS];
   logic [DATA_W-1:0] delay_now [CHANNELS];
   logic [DATA_W-1:0] delay_saved [CHANNELS];
   logic [DATA_W-1:0] tick_cnt [CHANNELS];
   logic              armed [CHANNELS];
   logic              gate [CHANNELS];

   dimmer_rsp_type pending_rsp [$];
   stim_row_type   directed_rows [$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          stalled_cycles = 0;
   bit          idle_on = 1'b1;

   multi_channel_phase_dimmer_unit DUT (.*);

   always #4 clock = ~clock;

   always @(posedge clock) rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);

   function automatic logic [DATA_W-1:0] brightness_to_delay(input logic [DATA_W-1:0] v);
      int span_in, span_out, r;
      if (cfg_max_b <= cfg_min_b)
         return cfg_min_d;
      span_in  = int'(cfg_max_b) - int'(cfg_min_b);
      span_out = int'(cfg_max_d) - int'(cfg_min_d);
      r = (int'(v) - int'(cfg_min_b)) * span_out / span_in + int'(cfg_min_d);
      return r[DATA_W-1:0];
   endfunction

   task automatic reset_dimmer();
      cfg_enable = '0;
      cfg_min_b  = '0;
      cfg_max_b  = BRIGHT_RST;
      cfg_min_d  = '0;
      cfg_max_d  = DELAY_RST;
      for (int i = 0; i < CHANNELS; i++) begin
         bright_now[i]   = BRIGHT_RST;
         bright_saved[i] = BRIGHT_RST;
         delay_now[i]    = DELAY_RST;
         delay_saved[i]  = DELAY_RST;
         tick_cnt[i]     = '0;
         armed[i]        = 1'b0;
         gate[i]         = 1'b0;
      end
   endtask

   task automatic advance_dimmer(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                                 input logic [DATA_W-1:0] value, output dimmer_rsp_type rsp);
      logic [DATA_W-1:0] v;
      rsp.bright = '0;
      case (kind)
         KIND_ZERO: begin
            for (int i = 0; i < CHANNELS; i++)
               if (cfg_enable[i]) begin
                  armed[i]    = 1'b1;
                  tick_cnt[i] = '0;
                  gate[i]     = 1'b0;
               end
         end
         KIND_TICK: begin
            for (int i = 0; i < CHANNELS; i++)
               if (cfg_enable[i] && delay_now[i] != cfg_min_d && armed[i]) begin
                  if (tick_cnt[i] >= delay_now[i]) begin
                     gate[i]     = 1'b1;
                     tick_cnt[i] = '0;
                     armed[i]    = 1'b0;
                  end else if (tick_cnt[i] != 8'hFF) begin
                     tick_cnt[i] = tick_cnt[i] + 8'd1;
                  end
               end
         end
         KIND_SET: begin
            v = value;
            if (v < cfg_min_b) v = cfg_min_b;
            if (v > cfg_max_b) v = cfg_max_b;
            bright_saved[ch] = bright_now[ch];
            bright_now[ch]   = v;
            delay_now[ch]    = brightness_to_delay(v);
         end
         KIND_ON: begin
            bright_now[ch] = bright_saved[ch];
            delay_now[ch]  = delay_saved[ch];
         end
         KIND_OFF: begin
            bright_saved[ch] = bright_now[ch];
            delay_saved[ch]  = delay_now[ch];
            delay_now[ch]    = cfg_min_d;
            bright_now[ch]   = cfg_min_b;
         end
         KIND_GET: begin
            rsp.bright = (bright_now[ch] == cfg_min_b) ? bright_saved[ch] : bright_now[ch];
         end
         default: begin
         end
      endcase
      for (int i = 0; i < CHANNELS; i++)
         rsp.gates[i] = gate[i];
   endtask

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                            input logic [DATA_W-1:0] value, input bit checked,
                            input dimmer_rsp_type typed_rsp);
      dimmer_rsp_type predicted;
      csr_valid <= 1'b0;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_channel <= ch;
      req_value   <= value;
      do @(posedge clock); while (req_stall);
      advance_dimmer(kind, ch, value, predicted);
      pending_rsp.push_back(checked ? typed_rsp : predicted);
      items_sent++;
   endtask

   task automatic send(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                       input logic [DATA_W-1:0] value);
      send_item(kind, ch, value, 1'b0, '0);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no gap
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CHANNEL_ENABLE: cfg_enable = data;
         CSR_MIN_BRIGHTNESS: cfg_min_b  = data;
         CSR_MAX_BRIGHTNESS: cfg_max_b  = data;
         CSR_MIN_DELAY:      cfg_min_d  = data;
         CSR_MAX_DELAY:      cfg_max_d  = data;
         default: begin
         end
      endcase
   endtask

   task automatic load_config(input logic [DATA_W-1:0] enable, input logic [DATA_W-1:0] min_b,
                              input logic [DATA_W-1:0] max_b, input logic [DATA_W-1:0] min_d,
                              input logic [DATA_W-1:0] max_d);
      wait_idle();
      write_reg(CSR_CHANNEL_ENABLE, enable);
      write_reg(CSR_MIN_BRIGHTNESS, min_b);
      write_reg(CSR_MAX_BRIGHTNESS, max_b);
      write_reg(CSR_MIN_DELAY, min_d);
      write_reg(CSR_MAX_DELAY, max_d);
   endtask

   function automatic void add_row(input row_kind_type row, input logic [KIND_W-1:0] kind,
                                   input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] value,
                                   input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CHANNELS-1:0] gates,
                                   input logic [DATA_W-1:0] bright);
      stim_row_type r;
      r.row        = row;
      r.kind       = kind;
      r.ch         = ch;
      r.value      = value;
      r.idx        = idx;
      r.rsp.gates  = gates;
      r.rsp.bright = bright;
      directed_rows.push_back(r);
   endfunction

   always @(posedge clock) begin : result_check
      dimmer_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: gates %h brightness %0d",
                        rsp_gate_outputs, rsp_brightness_reported);
         end else begin
            want = pending_rsp.pop_front();
            if (want.gates !== rsp_gate_outputs || want.bright !== rsp_brightness_reported) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: gates exp %h got %h, brightness exp %0d got %0d",
                           want.gates, rsp_gate_outputs, want.bright,
                           rsp_brightness_reported);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("multi_channel_phase_dimmer_unit_test: FAIL");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type row;
      int        n, r, phase, next_cfg_at, directed_items;

      reset_dimmer();

      // defaults, all channels disabled
      add_row(ROW_CHECKED, KIND_GET,    3'd0, 8'd0,   '0, 8'h00, 8'd100);
      add_row(ROW_CHECKED, KIND_GET,    3'd7, 8'd255, '0, 8'h00, 8'd100);
      add_row(ROW_CHECKED, KIND_RSVD_A, 3'd3, 8'd255, '0, 8'h00, 8'd0);
      add_row(ROW_CHECKED, KIND_RSVD_B, 3'd7, 8'd0,   '0, 8'h00, 8'd0);
      add_row(ROW_CHECKED, KIND_ZERO,   3'd0, 8'd0,   '0, 8'h00, 8'd0);
      add_row(ROW_CHECKED, KIND_TICK,   3'd0, 8'd0,   '0, 8'h00, 8'd0);
      add_row(ROW_CHECKED, KIND_SET,    3'd0, 8'd255, '0, 8'h00, 8'd0);
      add_row(ROW_CHECKED, KIND_SET,    3'd1, 8'd0,   '0, 8'h00, 8'd0);
      // channel at min brightness reports its saved value
      add_row(ROW_CHECKED, KIND_GET,    3'd1, 8'd0,   '0, 8'h00, 8'd100);
      add_row(ROW_CHECKED, KIND_OFF,    3'd2, 8'd0,   '0, 8'h00, 8'd0);
      add_row(ROW_CHECKED, KIND_GET,    3'd2, 8'd0,   '0, 8'h00, 8'd100);
      add_row(ROW_CHECKED, KIND_ON,     3'd2, 8'd0,   '0, 8'h00, 8'd0);
      add_row(ROW_CHECKED, KIND_GET,    3'd2, 8'd0,   '0, 8'h00, 8'd100);
      // short delays so gates fire
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'hFF,  CSR_CHANNEL_ENABLE, '0, '0);
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'd4,   CSR_MAX_DELAY,      '0, '0);
      add_row(ROW_ITEM,    KIND_SET,    3'd0, 8'd100, '0, '0, '0);
      add_row(ROW_ITEM,    KIND_SET,    3'd4, 8'd50,  '0, '0, '0);
      add_row(ROW_CHECKED, KIND_ZERO,   3'd0, 8'd0,   '0, 8'h00, 8'd0);
      for (int i = 0; i < 5; i++)
         add_row(ROW_ITEM, KIND_TICK,   3'd0, 8'd0,   '0, '0, '0);
      // empty brightness range
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'd10,  CSR_MIN_BRIGHTNESS, '0, '0);
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'd10,  CSR_MAX_BRIGHTNESS, '0, '0);
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'd7,   CSR_MIN_DELAY,      '0, '0);
      add_row(ROW_ITEM,    KIND_SET,    3'd5, 8'd200, '0, '0, '0);
      add_row(ROW_ITEM,    KIND_GET,    3'd5, 8'd0,   '0, '0, '0);
      // inverted delay map at the extremes
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'd0,   CSR_MIN_BRIGHTNESS, '0, '0);
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'd255, CSR_MAX_BRIGHTNESS, '0, '0);
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'd255, CSR_MIN_DELAY,      '0, '0);
      add_row(ROW_REG,     KIND_ZERO,   3'd0, 8'd0,   CSR_MAX_DELAY,      '0, '0);
      add_row(ROW_ITEM,    KIND_SET,    3'd6, 8'd255, '0, '0, '0);
      add_row(ROW_ITEM,    KIND_SET,    3'd6, 8'd128, '0, '0, '0);
      add_row(ROW_ITEM,    KIND_OFF,    3'd6, 8'd0,   '0, '0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.row == ROW_REG) begin
            wait_idle();
            write_reg(row.idx, row.value);
         end else begin
            send_item(row.kind, row.ch, row.value, row.row == ROW_CHECKED, row.rsp);
         end
      end

      directed_items = items_sent;
      next_cfg_at    = items_sent;
      phase          = 0;
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         if (items_sent >= next_cfg_at) begin
            case (phase)
               0: load_config(8'hFF, 8'd0, 8'd255, 8'd0, 8'd255);
               1: load_config(DATA_W'($urandom_range(255)), 8'd255, 8'd1, 8'd255, 8'd0);
               default: load_config(DATA_W'($urandom_range(255)),
                                    DATA_W'($urandom_range(30)),
                                    DATA_W'($urandom_range(255, 1)),
                                    DATA_W'($urandom_range(3)),
                                    DATA_W'($urandom_range(24)));
            endcase
            idle_on     = (phase != 3);
            next_cfg_at = next_cfg_at + PHASE_ITEMS;
            phase++;
         end
         if ($urandom_range(99) < 75) begin
            // one half cycle: zero cross, then a run of ticks with commands mixed in
            n = $urandom_range(30);
            send(KIND_ZERO, CH_W'($urandom_range(CHANNELS-1)), DATA_W'($urandom_range(255)));
            repeat (n) begin
               r = $urandom_range(99);
               if (r < 8)
                  send(KIND_SET, CH_W'($urandom_range(CHANNELS-1)),
                       DATA_W'($urandom_range(255)));
               else if (r < 11)
                  send(KIND_ON, CH_W'($urandom_range(CHANNELS-1)),
                       DATA_W'($urandom_range(255)));
               else if (r < 14)
                  send(KIND_OFF, CH_W'($urandom_range(CHANNELS-1)),
                       DATA_W'($urandom_range(255)));
               else if (r < 20)
                  send(KIND_GET, CH_W'($urandom_range(CHANNELS-1)),
                       DATA_W'($urandom_range(255)));
               send(KIND_TICK, CH_W'($urandom_range(CHANNELS-1)),
                    DATA_W'($urandom_range(255)));
            end
         end else begin
            send(KIND_W'($urandom_range(7)), CH_W'($urandom_range(CHANNELS-1)),
                 DATA_W'($urandom_range(255)));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("multi_channel_phase_dimmer_unit_test: PASS");
      else
         $display("multi_channel_phase_dimmer_unit_test: FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
src/mcpd_pkg.sv
src/mcpd_div.sv
src/mcpd_dp.sv
src/mcpd_ctrl.sv
src/multi_channel_phase_dimmer_unit.sv
tb/multi_channel_phase_dimmer_unit_test.sv
